// ===== hw/rtl/fet_pkg.sv =====
// shared types and constants for the fault event table
package fet_pkg;

  localparam logic [1:0] OP_REPORT  = 2'd0;
  localparam logic [1:0] OP_RESOLVE = 2'd1;
  localparam logic [1:0] OP_ACK     = 2'd2;
  localparam logic [1:0] OP_NOTICE  = 2'd3;

  localparam logic [2:0] ST_CREATED   = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_THROTTLED = 3'd2;
  localparam logic [2:0] ST_RESOLVED  = 3'd3;
  localparam logic [2:0] ST_ACKED     = 3'd4;
  localparam logic [2:0] ST_NOTFOUND  = 3'd5;
  localparam logic [2:0] ST_TAKEN     = 3'd6;
  localparam logic [2:0] ST_NONOTICE  = 3'd7;

  localparam logic [0:0] CFG_THROTTLE = 1'd0;
  localparam logic [0:0] CFG_NOTIFY   = 1'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [7:0]  component_id;
    logic [7:0]  fault_code;
    logic [1:0]  severity_in;
    logic [15:0] target_tag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] event_tag;
    logic [31:0] occurrences;
    logic [1:0]  entry_severity;
    logic        notify;
    logic        evicted;
    logic [15:0] evicted_tag;
    logic [1:0]  health;
    logic [5:0]  active_count;
  } rsp_t;

  // one table entry as it sits in a cell
  typedef struct packed {
    logic        valid;
    logic        active;
    logic        acked;
    logic [1:0]  sev;
    logic [7:0]  comp;
    logic [7:0]  code;
    logic [15:0] tag;
    logic [31:0] last_seen;
    logic [31:0] count;
  } entry_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic        load;      // write new entry at the cell flagged by sel
    logic        upd;       // rewrite the cell flagged by sel
    logic        clr_act;   // resolve the selected cell
    logic        set_ack;   // acknowledge the selected cell
    logic        shift;     // cells flagged by shen take their upper neighbour
    entry_t      wdata;
  } cmd_t;

endpackage

// ===== hw/rtl/fet_cell.sv =====
// one table slot: holds an entry and can take its upper neighbour's entry
module fet_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fet_pkg::cmd_t   cmd_i,
  input  logic            sel_i,
  input  logic            shift_en_i,
  input  fet_pkg::entry_t up_i,
  output fet_pkg::entry_t ent_o
);

  fet_pkg::entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.shift && shift_en_i) begin
      ent_d = up_i;
    end else if (sel_i) begin
      if (cmd_i.load || cmd_i.upd) ent_d = cmd_i.wdata;
      if (cmd_i.clr_act) ent_d.active = 1'b0;
      if (cmd_i.set_ack) ent_d.acked = 1'b1;
    end
  end

  // whole entry cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

// ===== hw/rtl/fault_event_table.sv =====
// fault event table top level: chain of entry cells and a sequencing controller
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid_i/ready  | fet_pkg::req_t
//  rsp     | out       | rsp_valid_o/ready  | fet_pkg::rsp_t
//  cfg     | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// one item at a time: lookup, update/evict shift, then a summary cycle; a new item
// is accepted only after the previous one has finished its summary cycle.
// match, oldest-pick and active summary are priority/count trees over the cell row.
// reset clears valid/active bits of every cell, no clearing pass needed.
// a held result stalls the next item only until the result register is taken.
module fault_event_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  fet_pkg::req_t  req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output fet_pkg::rsp_t  rsp_o,
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int FW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC, S_SUM} state_e;

  state_e          state_q;
  fet_pkg::req_t   req_q;
  fet_pkg::rsp_t   rsp_q;
  fet_pkg::rsp_t   rsp_d;
  logic            rsp_valid_q;
  logic [31:0]     throttle_q;
  logic [1:0]      nmin_q;
  logic [15:0]     tagc_q;
  logic            npend_q;
  logic [15:0]     ntag_q;
  logic [FW-1:0]   fill_q;

  fet_pkg::cmd_t   cmd;
  fet_pkg::entry_t ent   [TABLE_DEPTH];
  fet_pkg::entry_t upn   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] sel, shen;

  // lookup results, registered
  logic            hit_q;
  logic [IW-1:0]   hidx_q;
  logic [IW-1:0]   vidx_q;
  fet_pkg::entry_t hent_q;

  // combinational searches over the row
  logic            hit_c, v_c;
  logic [IW-1:0]   hidx_c, vidx_c;
  logic [IW-1:0]   ra_idx, r_idx;
  logic            ra_f, r_f;
  logic [5:0]      act_c;
  logic [1:0]      hlth_c;

  always_comb begin
    hit_c = 1'b0; hidx_c = '0;
    ra_f = 1'b0; ra_idx = '0; r_f = 1'b0; r_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (req_q.opcode == fet_pkg::OP_ACK) begin
        if (ent[i].valid && ent[i].tag == req_q.target_tag) begin
          hit_c = 1'b1; hidx_c = IW'(i);
        end
      end else if (ent[i].active && ent[i].comp == req_q.component_id &&
                   ent[i].code == req_q.fault_code) begin
        hit_c = 1'b1; hidx_c = IW'(i);
      end
      if (ent[i].valid && !ent[i].active && ent[i].acked) begin
        ra_f = 1'b1; ra_idx = IW'(i);
      end
      if (ent[i].valid && !ent[i].active) begin
        r_f = 1'b1; r_idx = IW'(i);
      end
    end
    v_c = ra_f | r_f;
    vidx_c = ra_f ? ra_idx : (r_f ? r_idx : '0);
  end

  always_comb begin
    act_c = '0; hlth_c = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (ent[i].valid && ent[i].active) begin
        act_c = act_c + 6'd1;
        if (ent[i].sev > hlth_c) hlth_c = ent[i].sev;
      end
    end
  end

  logic full;
  assign full = (fill_q == FW'(TABLE_DEPTH));

  // exec-cycle decisions
  logic        esc, fresh, thr;
  logic [15:0] ntag;
  assign esc   = req_q.severity_in > hent_q.sev;
  assign fresh = (req_q.now_ms - hent_q.last_seen) >= throttle_q;
  assign thr   = !esc && !fresh;
  assign ntag  = tagc_q + 16'd1;

  logic [IW-1:0] wpos;
  assign wpos = full ? IW'(TABLE_DEPTH - 1) : fill_q[IW-1:0];

  always_comb begin
    cmd = '0;
    sel = '0;
    shen = '0;
    if (state_q == S_EXEC) begin
      unique case (req_q.opcode)
        fet_pkg::OP_REPORT: begin
          if (hit_q) begin
            cmd.upd = !thr;
            cmd.wdata = hent_q;
            if (esc) cmd.wdata.sev = req_q.severity_in;
            if (fresh) begin
              cmd.wdata.last_seen = req_q.now_ms;
              if (hent_q.count != '1) cmd.wdata.count = hent_q.count + 32'd1;
            end
            sel[hidx_q] = 1'b1;
          end else begin
            cmd.load = 1'b1;
            cmd.shift = full;
            cmd.wdata.valid = 1'b1;
            cmd.wdata.active = 1'b1;
            cmd.wdata.acked = 1'b0;
            cmd.wdata.sev = req_q.severity_in;
            cmd.wdata.comp = req_q.component_id;
            cmd.wdata.code = req_q.fault_code;
            cmd.wdata.tag = ntag;
            cmd.wdata.last_seen = req_q.now_ms;
            cmd.wdata.count = 32'd1;
            sel[wpos] = 1'b1;
            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
              shen[i] = full && (IW'(i) >= vidx_q);
            end
          end
        end
        fet_pkg::OP_RESOLVE: begin
          cmd.clr_act = hit_q;
          sel[hidx_q] = hit_q;
        end
        fet_pkg::OP_ACK: begin
          cmd.set_ack = hit_q;
          sel[hidx_q] = hit_q;
        end
        default: ;
      endcase
    end
  end

  // result fields settled in the exec cycle
  always_comb begin
    rsp_d = '0;
    rsp_d.status = fet_pkg::ST_NOTFOUND;
    unique case (req_q.opcode) inside
      fet_pkg::OP_REPORT: begin
        if (hit_q) begin
          rsp_d.status = thr ? fet_pkg::ST_THROTTLED : fet_pkg::ST_UPDATED;
          rsp_d.event_tag = hent_q.tag;
          rsp_d.occurrences = thr ? hent_q.count : cmd.wdata.count;
          rsp_d.entry_severity = thr ? hent_q.sev : cmd.wdata.sev;
          rsp_d.notify = esc && (req_q.severity_in >= nmin_q) && !npend_q;
        end else begin
          rsp_d.status = fet_pkg::ST_CREATED;
          rsp_d.event_tag = ntag;
          rsp_d.occurrences = 32'd1;
          rsp_d.entry_severity = req_q.severity_in;
          rsp_d.evicted = full;
          rsp_d.evicted_tag = full ? ent[vidx_q].tag : '0;
          rsp_d.notify = (req_q.severity_in >= nmin_q);
        end
      end
      fet_pkg::OP_RESOLVE, fet_pkg::OP_ACK: begin
        if (hit_q) begin
          rsp_d.status = (req_q.opcode == fet_pkg::OP_ACK) ?
                         fet_pkg::ST_ACKED : fet_pkg::ST_RESOLVED;
          rsp_d.event_tag = hent_q.tag;
          rsp_d.occurrences = hent_q.count;
          rsp_d.entry_severity = hent_q.sev;
        end
      end
      default: begin
        if (npend_q) begin
          rsp_d.status = fet_pkg::ST_TAKEN;
          rsp_d.event_tag = ntag_q;
        end else begin
          rsp_d.status = fet_pkg::ST_NONOTICE;
        end
      end
    endcase
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == TABLE_DEPTH - 1) begin : g_top
      assign upn[g] = cmd.wdata;
    end else begin : g_mid
      assign upn[g] = ent[g+1];
    end
    fet_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .sel_i      (sel[g] && !(cmd.shift && g != TABLE_DEPTH - 1)),
      .shift_en_i (shen[g]),
      .up_i       (upn[g]),
      .ent_o      (ent[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      throttle_q  <= 32'd1000;
      nmin_q      <= 2'd2;
      tagc_q      <= '0;
      npend_q     <= 1'b0;
      ntag_q      <= '0;
      fill_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fet_pkg::CFG_THROTTLE: throttle_q <= cfg_data_i;
          fet_pkg::CFG_NOTIFY:   nmin_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req_valid_i && req_ready_o) state_q <= S_LOOK;
        S_LOOK: begin
          hit_q  <= hit_c;
          hidx_q <= hidx_c;
          vidx_q <= v_c ? vidx_c : '0;
          hent_q <= ent[hidx_c];
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          rsp_q <= rsp_d;
          if (req_q.opcode == fet_pkg::OP_REPORT) begin
            if (!hit_q) begin
              tagc_q <= ntag;
              if (!full) fill_q <= fill_q + FW'(1);
            end
            if (rsp_d.notify) begin
              npend_q <= 1'b1;
              ntag_q <= rsp_d.event_tag;
            end
          end else if (req_q.opcode == fet_pkg::OP_NOTICE) begin
            npend_q <= 1'b0;
          end
          state_q <= S_SUM;
        end
        S_SUM: begin
          rsp_q.health <= hlth_c;
          rsp_q.active_count <= act_c;
          rsp_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) req_q <= req_i;
  end

  // accept once idle and the previous result is gone or leaving
  assign req_ready_o = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready_i);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
